[rtl/pcmc_pkg.sv]
`default_nettype none

package pcmc_pkg;

  // command codes
  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_COLUMN = 2'd1,
    CMD_VOTE   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  localparam int POS_BITS = 14;
  localparam int SYM_BITS = 3;
  localparam int COV_OUT_BITS = 16;
  localparam int MIN_COV_BITS = 16;

  // symbol codes, gap is the highest counted one
  localparam logic [SYM_BITS-1:0] SYM_A   = 3'd0;
  localparam logic [SYM_BITS-1:0] SYM_GAP = 3'd4;

  // lanes of one pileup entry: five symbol counts then coverage
  localparam int NUM_SYM = 5;
  localparam int COV_LANE = 5;
  localparam int NUM_LANES = 6;

  localparam logic [MIN_COV_BITS-1:0] MIN_COV_RESET = 16'd4;

  typedef struct packed {
    cmd_t                command;
    logic [POS_BITS-1:0] position;
    logic [SYM_BITS-1:0] query_symbol;
    logic                target_is_gap;
    logic [SYM_BITS-1:0] original_base;
  } in_word_t;

  typedef struct packed {
    logic [SYM_BITS-1:0]     consensus_symbol;
    logic                    covered;
    logic [COV_OUT_BITS-1:0] coverage;
    logic                    position_error;
  } out_word_t;

endpackage

`default_nettype wire

[rtl/pcmc_in_if.sv]
`default_nettype none

interface pcmc_in_if import pcmc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

[rtl/pcmc_out_if.sv]
`default_nettype none

interface pcmc_out_if import pcmc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

[rtl/pileup_count_majority_consensus.sv]
`default_nettype none

// a vote word (or a column error) goes from the modify stage through the result register once its request word is taken
// throughput: one request word per cycle while the result side takes its words
// the rate is set by the single pileup memory: read at accept, modify and write back from the modify stage
// reset: a clearing pass writes every entry to zero, with request.ready low
// reset also sets min_coverage to 4 and the running position to 0
module pileup_count_majority_consensus import pcmc_pkg::*; #(
  parameter int TEMPLATE_LEN = 16384,
  parameter int COUNT_BITS   = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_wr_en,
  input  wire logic [MIN_COV_BITS-1:0] cfg_wr_data,
  pcmc_in_if.sink                      request,
  pcmc_out_if.source                   result
);

  localparam int ADDR_W = $clog2(TEMPLATE_LEN);
  // running position holds any begin position and the end-of-template mark
  localparam int RP_W = ($clog2(TEMPLATE_LEN + 1) > POS_BITS) ? $clog2(TEMPLATE_LEN + 1)
                                                                : POS_BITS;
  localparam int TW = COUNT_BITS + 3;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [NUM_LANES-1:0][COUNT_BITS-1:0] entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (&v) ? v : cnt_t'(v + 1'b1);
  endfunction

  // control state
  state_t            state;
  logic [ADDR_W-1:0] clr_addr;
  logic [RP_W-1:0]   rp;
  logic [MIN_COV_BITS-1:0] min_coverage;

  // pileup memory, one wide entry per template position
  entry_t mem [TEMPLATE_LEN];
  entry_t rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;

  // request decode at accept
  logic              req_accept;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_in_range;
  logic              pos_in_range;
  logic              rp_in_range;

  // modify stage
  logic              s1_valid;
  cmd_t              s1_cmd;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_in_range;
  logic [SYM_BITS-1:0] s1_qsym;
  logic              s1_tgap;
  logic [SYM_BITS-1:0] s1_obase;
  logic              fwd_hit;
  entry_t            fwd_data;

  logic   s1_result;
  logic   s1_write;
  logic   s1_adv;
  entry_t cur;
  entry_t upd;

  // vote datapath
  cnt_t                best;
  logic [SYM_BITS-1:0] best_k;
  logic                found;
  logic                cov_ok;
  logic                thr_ok;
  logic [TW-1:0]       best5;
  logic [TW-1:0]       cov3;
  logic [COV_OUT_BITS-1:0] cov_out;
  out_word_t           res_next;

  // output register
  logic      out_valid;
  out_word_t out_word;

  assign pos_in_range = 32'(request.word.position) < 32'(TEMPLATE_LEN);
  assign rp_in_range  = rp < RP_W'(TEMPLATE_LEN);

  always_comb begin
    if (request.word.command == CMD_COLUMN) begin
      rd_addr     = ADDR_W'(rp);
      rd_in_range = rp_in_range;
    end else begin
      rd_addr     = ADDR_W'(request.word.position);
      rd_in_range = pos_in_range;
    end
  end

  // the modify stage issues a word only when the result register can take it
  assign s1_result = s1_valid && ((s1_cmd == CMD_VOTE) ||
                     ((s1_cmd == CMD_COLUMN) && !s1_tgap && !s1_in_range));
  assign s1_adv    = !s1_result || !out_valid || result.ready;
  assign s1_write  = s1_valid && s1_in_range &&
                     (((s1_cmd == CMD_COLUMN) && !s1_tgap) || (s1_cmd == CMD_CLEAR));

  assign request.ready = (state == ST_RUN) && (!s1_valid || s1_adv);
  assign req_accept    = request.valid && request.ready;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_coverage <= MIN_COV_RESET;
    end else if (cfg_wr_en) begin
      min_coverage <= cfg_wr_data;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (clr_addr == ADDR_W'(TEMPLATE_LEN - 1)) begin
            state <= ST_RUN;
          end
          clr_addr <= clr_addr + 1'b1;
        end
        ST_RUN: begin
          state <= ST_RUN;
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // running position advances at accept, it never waits on the memory
  always_ff @(posedge clk) begin
    if (rst) begin
      rp <= '0;
    end else if (req_accept) begin
      if (request.word.command == CMD_BEGIN) begin
        rp <= RP_W'(request.word.position);
      end else if ((request.word.command == CMD_COLUMN) && !request.word.target_is_gap &&
                   rp_in_range) begin
        rp <= rp + 1'b1;
      end
    end
  end

  // memory write port: sweep zeros, then write back from the modify stage
  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_write && s1_adv;
      mem_waddr = s1_addr;
      mem_wdata = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // read returns the old entry when written at the same edge, so catch that write
  always_ff @(posedge clk) begin
    if (req_accept) begin
      rdata    <= mem[rd_addr];
      fwd_hit  <= mem_we && (mem_waddr == rd_addr);
      fwd_data <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      s1_cmd      <= request.word.command;
      s1_addr     <= rd_addr;
      s1_in_range <= rd_in_range;
      s1_qsym     <= request.word.query_symbol;
      s1_tgap     <= request.word.target_is_gap;
      s1_obase    <= (request.word.original_base > SYM_GAP) ? SYM_GAP
                                                             : request.word.original_base;
    end
  end

  assign cur = fwd_hit ? fwd_data : rdata;

  // read-modify-write of one entry
  always_comb begin
    upd = cur;
    if (s1_cmd == CMD_CLEAR) begin
      upd = '0;
    end else begin
      upd[COV_LANE] = sat_inc(cur[COV_LANE]);
      // other query symbols count toward coverage only
      if (s1_qsym <= SYM_GAP) begin
        upd[s1_qsym] = sat_inc(cur[s1_qsym]);
      end
    end
  end

  // majority vote, first symbol wins ties
  always_comb begin
    best   = cur[0];
    best_k = SYM_A;
    for (int k = 1; k < NUM_SYM; k++) begin
      if (cur[k] > best) begin
        best   = cur[k];
        best_k = SYM_BITS'(k);
      end
    end
  end

  assign found  = best != '0;
  assign cov_ok = 32'(cur[COV_LANE]) >= 32'(min_coverage);
  // 0.6 threshold as 5*max >= 3*coverage
  assign best5  = TW'(best) * TW'(5);
  assign cov3   = TW'(cur[COV_LANE]) * TW'(3);
  assign thr_ok = best5 >= cov3;
  assign cov_out = (32'(cur[COV_LANE]) > 32'(16'hFFFF)) ? 16'hFFFF
                                                         : COV_OUT_BITS'(cur[COV_LANE]);

  always_comb begin
    res_next = '0;
    if (s1_cmd == CMD_VOTE) begin
      if (s1_in_range) begin
        res_next.consensus_symbol = (found && cov_ok && thr_ok) ? best_k : s1_obase;
        res_next.covered          = cov_ok;
        res_next.coverage         = cov_out;
      end else begin
        res_next.consensus_symbol = s1_obase;
        res_next.position_error   = 1'b1;
      end
    end else begin
      // column past the template end
      res_next.position_error = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_result && s1_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_result && s1_adv) begin
      out_word <= res_next;
    end
  end

  assign result.valid = out_valid;
  assign result.word  = out_word;

  // no request taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !request.ready)
    else $error("request ready during clearing pass");

  // the modify stage holds only behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |-> (out_valid && !result.ready))
    else $error("modify stage stalled without cause");

  // error words carry no coverage
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.word.position_error) |->
      (!result.word.covered && (result.word.coverage == '0)))
    else $error("error word with coverage");

  // no result symbol above gap
  a_sym_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.word.consensus_symbol <= SYM_GAP))
    else $error("consensus symbol out of range");

  // a write to the entry being read at accept is forwarded to the modify stage
  a_fwd_live: assert property (@(posedge clk) disable iff (rst)
    (req_accept && mem_we && (mem_waddr == rd_addr)) |=> fwd_hit)
    else $error("same-entry write not forwarded");

endmodule

`default_nettype wire
